// ----- rtl/planar_pose_frame_transform_macros.svh -----
`ifndef PLANAR_POSE_FRAME_TRANSFORM_MACROS_SVH
`define PLANAR_POSE_FRAME_TRANSFORM_MACROS_SVH

// same-cycle implication
`define PPFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppft: check failed");

// next-cycle implication
`define PPFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppft: check failed");

`endif

// ----- rtl/ppft_pkg.sv -----
package ppft_pkg;

    localparam int POSITION_WIDTH     = 32;
    localparam int ANGLE_WIDTH        = 16;
    localparam int TRIG_FRACTION_BITS = 16;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_X        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_Y        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HEADING  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_X       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_Y       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HEADING = 3'd5;

    localparam logic [1:0] ACT_PROPAGATE = 2'd0;
    localparam logic [1:0] ACT_V2L       = 2'd1;
    localparam logic [1:0] ACT_L2V       = 2'd2;

    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ANG_QUARTER = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] ANG_HALF    = 34'sd2147483648;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(logic [STEP_W-1:0] step);
        logic signed [CORDIC_W-1:0] v;
        unique case (step)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            5'd24:   v = 34'sd41;
            5'd25:   v = 34'sd20;
            5'd26:   v = 34'sd10;
            5'd27:   v = 34'sd5;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/planar_pose_frame_transform.sv -----
// Requests pass through a ten-stage pipeline, from capture to the output register.
// Throughput: one request per cycle while i_ready holds no stage back and
// no trig update is busy. A heading register write runs a 28-step iterative
// CORDIC plus a rounding step: inputs and config stall until it finishes.
// Reset (synchronous, active low) empties the pipeline, zeroes the poses and
// sets cosines to one and sines to zero.
module planar_pose_frame_transform #(
    parameter int POSITION_WIDTH     = ppft_pkg::POSITION_WIDTH,
    parameter int ANGLE_WIDTH        = ppft_pkg::ANGLE_WIDTH,
    parameter int TRIG_FRACTION_BITS = ppft_pkg::TRIG_FRACTION_BITS,
    localparam int CW = (POSITION_WIDTH > ANGLE_WIDTH) ? POSITION_WIDTH : ANGLE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_action,
    input  logic signed [POSITION_WIDTH-1:0]      i_point_x,
    input  logic signed [POSITION_WIDTH-1:0]      i_point_y,
    input  logic signed [ANGLE_WIDTH-1:0]         i_point_heading,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [POSITION_WIDTH-1:0]      o_out_x,
    output logic signed [POSITION_WIDTH-1:0]      o_out_y,
    output logic signed [ANGLE_WIDTH-1:0]         o_out_heading,
    output logic                                  o_saturated,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ppft_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CW-1:0]                         i_cfg_data
);

    localparam int P  = POSITION_WIDTH;
    localparam int A  = ANGLE_WIDTH;
    localparam int F  = TRIG_FRACTION_BITS;
    localparam int TW = F + 2;
    localparam int ZW = ppft_pkg::CORDIC_W;
    localparam int NS = 10;

    // first transform operands: P bits
    localparam int HA  = (P + 1) / 2;
    localparam int LA  = HA + 1;
    localparam int GA  = P - HA;
    localparam int HS1 = GA + TW + 1;
    localparam int LS1 = LA + TW + 1;
    localparam int SW1 = P + F + 4;
    localparam int D1W = P + 2;

    // second transform operands: QW bits
    localparam int QW  = P + 3;
    localparam int HB  = (QW + 1) / 2;
    localparam int LB  = HB + 1;
    localparam int GB  = QW - HB;
    localparam int HS2 = GB + TW + 1;
    localparam int LS2 = LB + TW + 1;
    localparam int SW2 = QW + F + 4;
    localparam int RW  = P + 5;

    localparam logic signed [SW1-1:0] RND1 = {{(SW1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [SW2-1:0] RND2 = {{(SW2-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [TW-1:0]  TRIG_ONE = {2'b01, {F{1'b0}}};
    localparam logic signed [F+4:0]   TONE5 = {4'b0000, 1'b1, {F{1'b0}}};
    localparam logic signed [34:0]    TRND = 35'sd1 <<< (29 - F);
    localparam logic signed [P-1:0]   PMAX = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0]   PMIN = {1'b1, {(P-1){1'b0}}};

    function automatic logic use_first(logic [1:0] act);
        return (act == ppft_pkg::ACT_PROPAGATE) || (act == ppft_pkg::ACT_V2L);
    endfunction

    function automatic logic use_second(logic [1:0] act);
        return (act == ppft_pkg::ACT_PROPAGATE) || (act == ppft_pkg::ACT_L2V);
    endfunction

    function automatic logic signed [TW-1:0] trig_round(logic signed [ZW-1:0] v);
        logic signed [34:0] s;
        logic signed [F+4:0] q;
        logic signed [TW-1:0] r;
        s = 35'(v) + TRND;
        q = (F+5)'(s >>> (30 - F));
        if (q > TONE5) begin
            r = TRIG_ONE;
        end else if (q < -TONE5) begin
            r = -TRIG_ONE;
        end else begin
            r = TW'(q);
        end
        return r;
    endfunction

    // ---------------- configuration and trig generation ----------------
    logic signed [P-1:0]  r_fx, r_fy, r_sx, r_sy;
    logic signed [A-1:0]  r_fh, r_sh;
    logic signed [TW-1:0] r_fc, r_fs, r_sc, r_ss;

    logic                          r_busy, r_fin, r_sel, r_flip;
    logic [ppft_pkg::STEP_W-1:0]   r_step;
    logic signed [ZW-1:0]          r_cx, r_cy, r_cz;

    logic                 cfg_acc;
    logic signed [31:0]   c_a;
    logic signed [ZW-1:0] c_a34, c_z0, c_dx, c_dy, c_atan, c_xf, c_yf;
    logic                 c_flip;

    assign o_cfg_ready = !r_busy;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        c_a   = $signed({i_cfg_data[A-1:0], {(32-A){1'b0}}});
        c_a34 = ZW'(c_a);
        if (c_a34 > ppft_pkg::ANG_QUARTER) begin
            c_z0   = c_a34 - ppft_pkg::ANG_HALF;
            c_flip = 1'b1;
        end else if (c_a34 < -ppft_pkg::ANG_QUARTER) begin
            c_z0   = c_a34 + ppft_pkg::ANG_HALF;
            c_flip = 1'b1;
        end else begin
            c_z0   = c_a34;
            c_flip = 1'b0;
        end
        c_dx   = r_cy >>> r_step;
        c_dy   = r_cx >>> r_step;
        c_atan = ppft_pkg::atan_turn(r_step);
        c_xf   = r_flip ? -r_cx : r_cx;
        c_yf   = r_flip ? -r_cy : r_cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx   <= '0;
            r_fy   <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_fh   <= '0;
            r_sh   <= '0;
            r_fc   <= TRIG_ONE;
            r_fs   <= '0;
            r_sc   <= TRIG_ONE;
            r_ss   <= '0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_sel  <= 1'b0;
            r_flip <= 1'b0;
            r_step <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                ppft_pkg::REG_FIRST_X:  r_fx <= $signed(i_cfg_data[P-1:0]);
                ppft_pkg::REG_FIRST_Y:  r_fy <= $signed(i_cfg_data[P-1:0]);
                ppft_pkg::REG_SECOND_X: r_sx <= $signed(i_cfg_data[P-1:0]);
                ppft_pkg::REG_SECOND_Y: r_sy <= $signed(i_cfg_data[P-1:0]);
                ppft_pkg::REG_FIRST_HEADING, ppft_pkg::REG_SECOND_HEADING: begin
                    if (i_cfg_index == ppft_pkg::REG_FIRST_HEADING) begin
                        r_fh <= $signed(i_cfg_data[A-1:0]);
                    end else begin
                        r_sh <= $signed(i_cfg_data[A-1:0]);
                    end
                    r_sel  <= (i_cfg_index == ppft_pkg::REG_SECOND_HEADING);
                    r_busy <= 1'b1;
                    r_fin  <= 1'b0;
                    r_step <= '0;
                    r_cx   <= ppft_pkg::CORDIC_GAIN;
                    r_cy   <= '0;
                    r_cz   <= c_z0;
                    r_flip <= c_flip;
                end
                default: ;
            endcase
        end else if (r_busy) begin
            if (r_fin) begin
                if (r_sel) begin
                    r_sc <= trig_round(c_xf);
                    r_ss <= trig_round(c_yf);
                end else begin
                    r_fc <= trig_round(c_xf);
                    r_fs <= trig_round(c_yf);
                end
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end else begin
                if (!r_cz[ZW-1]) begin
                    r_cx <= r_cx - c_dx;
                    r_cy <= r_cy + c_dy;
                    r_cz <= r_cz - c_atan;
                end else begin
                    r_cx <= r_cx + c_dx;
                    r_cy <= r_cy - c_dy;
                    r_cz <= r_cz + c_atan;
                end
                if (r_step == ppft_pkg::STEP_LAST) begin
                    r_fin <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;
    logic          in_acc;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0] && !r_busy;
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= in_acc;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // action and heading travel with the request
    logic [1:0]          r_act [0:7];
    logic signed [A-1:0] r_hd  [0:8];
    logic signed [A-1:0] n_hd;

    always_comb begin
        n_hd = i_point_heading;
        if (use_first(i_action)) begin
            n_hd = n_hd + r_fh;
        end
        if (use_second(i_action)) begin
            n_hd = n_hd - r_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_act[0] <= i_action;
            r_hd[0]  <= n_hd;
        end
        for (int k = 1; k < 8; k++) begin
            if (adv[k]) begin
                r_act[k] <= r_act[k-1];
            end
        end
        for (int k = 1; k < 9; k++) begin
            if (adv[k]) begin
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    // ---------------- stage 0: capture ----------------
    logic signed [P-1:0] r_s0_px, r_s0_py, r_s1_px, r_s1_py, r_s2_px, r_s2_py;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0_px <= i_point_x;
            r_s0_py <= i_point_y;
        end
    end

    // ---------------- stages 1-3: first rotation ----------------
    logic signed [GA-1:0] c1_px_h, c1_py_h;
    logic signed [LA-1:0] c1_px_l, c1_py_l;

    assign c1_px_h = $signed(r_s0_px[P-1:HA]);
    assign c1_py_h = $signed(r_s0_py[P-1:HA]);
    assign c1_px_l = $signed({1'b0, r_s0_px[HA-1:0]});
    assign c1_py_l = $signed({1'b0, r_s0_py[HA-1:0]});

    logic signed [GA+TW-1:0] r_s1_xc_h, r_s1_ys_h, r_s1_yc_h, r_s1_xs_h;
    logic signed [LA+TW-1:0] r_s1_xc_l, r_s1_ys_l, r_s1_yc_l, r_s1_xs_l;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_xc_h <= c1_px_h * r_fc;
            r_s1_ys_h <= c1_py_h * r_fs;
            r_s1_yc_h <= c1_py_h * r_fc;
            r_s1_xs_h <= c1_px_h * r_fs;
            r_s1_xc_l <= c1_px_l * r_fc;
            r_s1_ys_l <= c1_py_l * r_fs;
            r_s1_yc_l <= c1_py_l * r_fc;
            r_s1_xs_l <= c1_px_l * r_fs;
            r_s1_px   <= r_s0_px;
            r_s1_py   <= r_s0_py;
        end
    end

    logic signed [HS1-1:0] r_s2_x_h, r_s2_y_h;
    logic signed [LS1-1:0] r_s2_x_l, r_s2_y_l;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s2_x_h <= HS1'(r_s1_xc_h) - HS1'(r_s1_ys_h);
            r_s2_y_h <= HS1'(r_s1_yc_h) + HS1'(r_s1_xs_h);
            r_s2_x_l <= LS1'(r_s1_xc_l) - LS1'(r_s1_ys_l);
            r_s2_y_l <= LS1'(r_s1_yc_l) + LS1'(r_s1_xs_l);
            r_s2_px  <= r_s1_px;
            r_s2_py  <= r_s1_py;
        end
    end

    logic signed [SW1-1:0] c3_xs, c3_ys;
    logic signed [D1W-1:0] r_s3_x, r_s3_y, r_s4_x, r_s4_y;

    always_comb begin
        c3_xs = (SW1'(r_s2_x_h) <<< HA) + SW1'(r_s2_x_l) + RND1;
        c3_ys = (SW1'(r_s2_y_h) <<< HA) + SW1'(r_s2_y_l) + RND1;
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            if (use_first(r_act[2])) begin
                r_s3_x <= D1W'(c3_xs >>> F);
                r_s3_y <= D1W'(c3_ys >>> F);
            end else begin
                r_s3_x <= D1W'(r_s2_px);
                r_s3_y <= D1W'(r_s2_py);
            end
        end
    end

    // ---------------- stage 4: first translation ----------------
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            if (use_first(r_act[3])) begin
                r_s4_x <= r_s3_x + D1W'(r_fx);
                r_s4_y <= r_s3_y + D1W'(r_fy);
            end else begin
                r_s4_x <= r_s3_x;
                r_s4_y <= r_s3_y;
            end
        end
    end

    // ---------------- stage 5: second translation ----------------
    logic signed [QW-1:0] r_s5_x, r_s5_y, r_s6_dx, r_s6_dy, r_s7_dx, r_s7_dy;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            if (use_second(r_act[4])) begin
                r_s5_x <= QW'(r_s4_x) - QW'(r_sx);
                r_s5_y <= QW'(r_s4_y) - QW'(r_sy);
            end else begin
                r_s5_x <= QW'(r_s4_x);
                r_s5_y <= QW'(r_s4_y);
            end
        end
    end

    // ---------------- stages 6-8: second rotation ----------------
    logic signed [GB-1:0] c6_dx_h, c6_dy_h;
    logic signed [LB-1:0] c6_dx_l, c6_dy_l;

    assign c6_dx_h = $signed(r_s5_x[QW-1:HB]);
    assign c6_dy_h = $signed(r_s5_y[QW-1:HB]);
    assign c6_dx_l = $signed({1'b0, r_s5_x[HB-1:0]});
    assign c6_dy_l = $signed({1'b0, r_s5_y[HB-1:0]});

    logic signed [GB+TW-1:0] r_s6_xc_h, r_s6_ys_h, r_s6_yc_h, r_s6_xs_h;
    logic signed [LB+TW-1:0] r_s6_xc_l, r_s6_ys_l, r_s6_yc_l, r_s6_xs_l;

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s6_xc_h <= c6_dx_h * r_sc;
            r_s6_ys_h <= c6_dy_h * r_ss;
            r_s6_yc_h <= c6_dy_h * r_sc;
            r_s6_xs_h <= c6_dx_h * r_ss;
            r_s6_xc_l <= c6_dx_l * r_sc;
            r_s6_ys_l <= c6_dy_l * r_ss;
            r_s6_yc_l <= c6_dy_l * r_sc;
            r_s6_xs_l <= c6_dx_l * r_ss;
            r_s6_dx   <= r_s5_x;
            r_s6_dy   <= r_s5_y;
        end
    end

    logic signed [HS2-1:0] r_s7_x_h, r_s7_y_h;
    logic signed [LS2-1:0] r_s7_x_l, r_s7_y_l;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s7_x_h <= HS2'(r_s6_xc_h) + HS2'(r_s6_ys_h);
            r_s7_y_h <= HS2'(r_s6_yc_h) - HS2'(r_s6_xs_h);
            r_s7_x_l <= LS2'(r_s6_xc_l) + LS2'(r_s6_ys_l);
            r_s7_y_l <= LS2'(r_s6_yc_l) - LS2'(r_s6_xs_l);
            r_s7_dx  <= r_s6_dx;
            r_s7_dy  <= r_s6_dy;
        end
    end

    logic signed [SW2-1:0] c8_xs, c8_ys;
    logic signed [RW-1:0]  r_s8_x, r_s8_y;

    always_comb begin
        c8_xs = (SW2'(r_s7_x_h) <<< HB) + SW2'(r_s7_x_l) + RND2;
        c8_ys = (SW2'(r_s7_y_h) <<< HB) + SW2'(r_s7_y_l) + RND2;
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            if (use_second(r_act[7])) begin
                r_s8_x <= RW'(c8_xs >>> F);
                r_s8_y <= RW'(c8_ys >>> F);
            end else begin
                r_s8_x <= RW'(r_s7_dx);
                r_s8_y <= RW'(r_s7_dy);
            end
        end
    end

    // ---------------- stage 9: saturation, output register ----------------
    logic                r_out_sat;
    logic signed [P-1:0] r_out_x, r_out_y;
    logic signed [A-1:0] r_out_hd;
    logic                c9_x_ok, c9_y_ok;
    logic signed [P-1:0] c9_x, c9_y;

    always_comb begin
        c9_x_ok = (&r_s8_x[RW-1:P-1]) || !(|r_s8_x[RW-1:P-1]);
        c9_y_ok = (&r_s8_y[RW-1:P-1]) || !(|r_s8_y[RW-1:P-1]);
        c9_x    = c9_x_ok ? P'(r_s8_x) : (r_s8_x[RW-1] ? PMIN : PMAX);
        c9_y    = c9_y_ok ? P'(r_s8_y) : (r_s8_y[RW-1] ? PMIN : PMAX);
    end

    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            r_out_x   <= c9_x;
            r_out_y   <= c9_y;
            r_out_hd  <= r_hd[8];
            r_out_sat <= !(c9_x_ok && c9_y_ok);
        end
    end

    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_heading = r_out_hd;
    assign o_saturated   = r_out_sat;

endmodule

// ----- rtl/ppft_checker.sv -----
`include "planar_pose_frame_transform_macros.svh"

module ppft_checker #(
    parameter int POSITION_WIDTH = ppft_pkg::POSITION_WIDTH
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [POSITION_WIDTH-1:0]          o_out_x,
    input logic [POSITION_WIDTH-1:0]          o_out_y,
    input logic                               o_saturated,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [ppft_pkg::CFG_INDEX_W-1:0]   i_cfg_index
);

    localparam logic [POSITION_WIDTH-1:0] PMAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    localparam logic [POSITION_WIDTH-1:0] PMIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

    logic heading_wr;
    logic in_acc;
    logic at_limit;

    assign heading_wr = i_cfg_valid && o_cfg_ready &&
                        (i_cfg_index == ppft_pkg::REG_FIRST_HEADING ||
                         i_cfg_index == ppft_pkg::REG_SECOND_HEADING);
    assign in_acc     = i_valid && o_ready;
    assign at_limit   = (o_out_x == PMAX) || (o_out_x == PMIN) ||
                        (o_out_y == PMAX) || (o_out_y == PMIN);

    `PPFT_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PPFT_ASSERT_NOW(a_no_request_while_trig_busy, i_clk, i_rst_n, in_acc, o_cfg_ready)
    `PPFT_ASSERT_NEXT(a_heading_write_busy, i_clk, i_rst_n, heading_wr, !o_ready && !o_cfg_ready)
    `PPFT_ASSERT_NOW(a_sat_at_limit, i_clk, i_rst_n, o_valid && o_saturated, at_limit)

endmodule

bind planar_pose_frame_transform ppft_checker #(
    .POSITION_WIDTH(POSITION_WIDTH)
) u_ppft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_saturated (o_saturated),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);
